>>> hw/rtl/casc_pkg.sv
`timescale 1ns / 1ps
package casc_pkg;

    localparam int COORD_W    = 32;
    localparam int RAD_W      = 31;
    localparam int ARCS_W     = 10;
    localparam int TOL_W      = 24;
    localparam int ANG_W      = 24;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int VEC_W      = COORD_W + 1;
    localparam int CW         = 64;
    localparam int ATAN_N     = 32;

    localparam int DEF_MAX_ARCS     = 360;
    localparam int DEF_CORDIC_STEPS = 24;

    localparam logic [ANG_W-1:0] HALF_TURN = 24'h800000;

    localparam logic [ANG_W-1:0] ATAN_TABLE [ATAN_N] = '{
        24'd2097152, 24'd1238021, 24'd654136, 24'd332050,
        24'd166669, 24'd83416, 24'd41718, 24'd20860,
        24'd10430, 24'd5215, 24'd2608, 24'd1304,
        24'd652, 24'd326, 24'd163, 24'd81,
        24'd41, 24'd20, 24'd10, 24'd5,
        24'd3, 24'd1, 24'd1, 24'd0,
        24'd0, 24'd0, 24'd0, 24'd0,
        24'd0, 24'd0, 24'd0, 24'd0
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AXIS_X  = 3'd0,
        CFG_AXIS_Y  = 3'd1,
        CFG_RADIUS  = 3'd2,
        CFG_ARCS    = 3'd3,
        CFG_LIN_TOL = 3'd4,
        CFG_ANG_TOL = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] axis_x;
        logic signed [COORD_W-1:0] axis_y;
        logic [RAD_W-1:0]          radius;
        logic [ARCS_W-1:0]         arcs;
        logic [TOL_W-1:0]          lin_tol;
        logic [ANG_W-1:0]          ang_tol;
    } cfg_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
    } vec_t;

    typedef struct packed {
        logic is_short;
        logic radius_ok;
        logic centre_ok;
    } front_t;

endpackage

>>> hw/rtl/cylindrical_arc_segment_check.sv
`timescale 1ns / 1ps
// One segment is accepted in every cycle; the pipeline holds as a whole only while a
// finished result waits in the output register and out_stall is high.
// Reset clears all valid bits and loads the configuration registers with their
// documented defaults; no clearing pass is needed.
module cylindrical_arc_segment_check #(
    parameter int MAX_ARCS     = casc_pkg::DEF_MAX_ARCS,
    parameter int CORDIC_STEPS = casc_pkg::DEF_CORDIC_STEPS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [casc_pkg::COORD_W-1:0]   seg_start_x,
    input  logic signed [casc_pkg::COORD_W-1:0]   seg_start_y,
    input  logic signed [casc_pkg::COORD_W-1:0]   seg_end_x,
    input  logic signed [casc_pkg::COORD_W-1:0]   seg_end_y,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  is_arc,
    input  logic                                  cfg_we,
    input  logic [casc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [casc_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import casc_pkg::*;

    cfg_t   cfg_reg;
    logic   adv;
    logic   front_valid, cordic_valid;
    front_t front_flags, cordic_flags;
    vec_t   start_vec, end_vec;
    logic [ANG_W-1:0] from_angle, end_angle;
    logic   zero_vec;

    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.axis_x  <= '0;
            cfg_reg.axis_y  <= '0;
            cfg_reg.radius  <= '0;
            cfg_reg.arcs    <= ARCS_W'(1);
            cfg_reg.lin_tol <= TOL_W'(50);
            cfg_reg.ang_tol <= ANG_W'(3);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_AXIS_X:  cfg_reg.axis_x  <= cfg_data;
                CFG_AXIS_Y:  cfg_reg.axis_y  <= cfg_data;
                CFG_RADIUS:  cfg_reg.radius  <= cfg_data[RAD_W-1:0];
                CFG_ARCS:    cfg_reg.arcs    <= cfg_data[ARCS_W-1:0];
                CFG_LIN_TOL: cfg_reg.lin_tol <= cfg_data[TOL_W-1:0];
                CFG_ANG_TOL: cfg_reg.ang_tol <= cfg_data[ANG_W-1:0];
                default:     cfg_reg         <= cfg_reg;
            endcase
        end
    end

    casc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .valid_in    (in_valid),
        .cfg         (cfg_reg),
        .seg_start_x (seg_start_x),
        .seg_start_y (seg_start_y),
        .seg_end_x   (seg_end_x),
        .seg_end_y   (seg_end_y),
        .valid_out   (front_valid),
        .flags       (front_flags),
        .start_vec   (start_vec),
        .end_vec     (end_vec)
    );

    casc_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .valid_in    (front_valid),
        .flags_in    (front_flags),
        .start_vec   (start_vec),
        .end_vec     (end_vec),
        .valid_out   (cordic_valid),
        .flags_out   (cordic_flags),
        .from_angle  (from_angle),
        .end_angle   (end_angle),
        .zero_vec    (zero_vec)
    );

    casc_decide #(
        .MAX_ARCS (MAX_ARCS)
    ) u_decide (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .valid_in    (cordic_valid),
        .cfg         (cfg_reg),
        .flags       (cordic_flags),
        .from_angle  (from_angle),
        .end_angle   (end_angle),
        .zero_vec    (zero_vec),
        .out_valid   (out_valid),
        .is_arc      (is_arc)
    );

endmodule

>>> hw/rtl/casc_front.sv
`timescale 1ns / 1ps
module casc_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic                                valid_in,
    input  casc_pkg::cfg_t                      cfg,
    input  logic signed [casc_pkg::COORD_W-1:0] seg_start_x,
    input  logic signed [casc_pkg::COORD_W-1:0] seg_start_y,
    input  logic signed [casc_pkg::COORD_W-1:0] seg_end_x,
    input  logic signed [casc_pkg::COORD_W-1:0] seg_end_y,
    output logic                                valid_out,
    output casc_pkg::front_t                    flags,
    output casc_pkg::vec_t                      start_vec,
    output casc_pkg::vec_t                      end_vec
);
    import casc_pkg::*;

    localparam int DEPTH = 7;

    function automatic logic in_range(input logic signed [VEC_W-1:0] v,
                                      input logic [COORD_W-1:0] h);
        logic signed [VEC_W:0] sv;
        logic signed [VEC_W:0] sh;
        sv = {v[VEC_W-1], v};
        sh = {2'b00, h};
        return (sv <= sh) && (sv >= -sh);
    endfunction

    logic [DEPTH-1:0] v_reg;
    vec_t vs_reg [DEPTH];
    vec_t ve_reg [DEPTH];

    logic signed [VEC_W-1:0] dx1_reg, dy1_reg;
    logic signed [VEC_W:0]   wx1_reg, wy1_reg;
    logic [COORD_W-1:0]      hi1_reg;
    logic [RAD_W-1:0]        lo1_reg;

    logic [2*COORD_W:0]      sxx2_reg, syy2_reg, exx2_reg, eyy2_reg, dxx2_reg, dyy2_reg;
    logic signed [2*VEC_W:0] pxd2_reg, pyd2_reg;
    logic [2*COORD_W-1:0]    hh2_reg;
    logic [2*RAD_W-1:0]      ll2_reg;
    logic [2*TOL_W-1:0]      tt2_reg;
    logic                    s_in2_reg, e_in2_reg, dx_in2_reg, dy_in2_reg;

    logic                      rad_ok3_reg, short3_reg;
    logic [2*COORD_W+1:0]      l3_reg;
    logic [2*TOL_W-1:0]        tt3_reg;
    logic signed [2*VEC_W+1:0] dot3_reg;

    logic        rad_ok4_reg, short4_reg, small4_reg;
    logic [57:0] dm4_reg;
    logic [56:0] p00_4_reg, p01_4_reg, p10_4_reg, p11_4_reg;

    logic         rad_ok5_reg, short5_reg, small5_reg;
    logic [57:0]  qa5_reg, qb5_reg, qc5_reg;
    logic [113:0] r5_reg;

    logic         rad_ok6_reg, short6_reg, small6_reg;
    logic [115:0] q6_reg;
    logic [113:0] r6_reg;

    front_t flags7_reg;

    logic signed [VEC_W-1:0] vsx_next, vsy_next, vex_next, vey_next, dx_next, dy_next;
    logic signed [VEC_W:0]   wx_next, wy_next;
    logic [COORD_W-1:0]      hi_next;
    logic [RAD_W-1:0]        lo_next;
    logic [COORD_W-1:0]      tol32;

    logic signed [2*VEC_W-1:0] sxx_next, syy_next, exx_next, eyy_next, dxx_next, dyy_next;
    logic signed [2*VEC_W:0]   pxd_next, pyd_next;

    logic [2*COORD_W+1:0]      d2s_next, d2e_next, l_next;
    logic signed [2*VEC_W+1:0] dot_next;
    logic                      on_s_next, on_e_next, short_next;

    logic [2*VEC_W+1:0] dm_next;
    logic [113:0]       r_next;
    logic [115:0]       q_next;

    always_comb
    begin
        tol32    = {8'b0, cfg.lin_tol};
        vsx_next = {seg_start_x[COORD_W-1], seg_start_x} - {cfg.axis_x[COORD_W-1], cfg.axis_x};
        vsy_next = {seg_start_y[COORD_W-1], seg_start_y} - {cfg.axis_y[COORD_W-1], cfg.axis_y};
        vex_next = {seg_end_x[COORD_W-1], seg_end_x} - {cfg.axis_x[COORD_W-1], cfg.axis_x};
        vey_next = {seg_end_y[COORD_W-1], seg_end_y} - {cfg.axis_y[COORD_W-1], cfg.axis_y};
        dx_next  = {seg_end_x[COORD_W-1], seg_end_x} - {seg_start_x[COORD_W-1], seg_start_x};
        dy_next  = {seg_end_y[COORD_W-1], seg_end_y} - {seg_start_y[COORD_W-1], seg_start_y};
        wx_next  = {cfg.axis_x[COORD_W-1], cfg.axis_x, 1'b0}
                 - {{2{seg_start_x[COORD_W-1]}}, seg_start_x}
                 - {{2{seg_end_x[COORD_W-1]}}, seg_end_x};
        wy_next  = {cfg.axis_y[COORD_W-1], cfg.axis_y, 1'b0}
                 - {{2{seg_start_y[COORD_W-1]}}, seg_start_y}
                 - {{2{seg_end_y[COORD_W-1]}}, seg_end_y};
        hi_next  = {1'b0, cfg.radius} + tol32;
        lo_next  = (cfg.radius > {7'b0, cfg.lin_tol}) ? cfg.radius - {7'b0, cfg.lin_tol} : '0;

        sxx_next = vs_reg[0].x * vs_reg[0].x;
        syy_next = vs_reg[0].y * vs_reg[0].y;
        exx_next = ve_reg[0].x * ve_reg[0].x;
        eyy_next = ve_reg[0].y * ve_reg[0].y;
        dxx_next = dx1_reg * dx1_reg;
        dyy_next = dy1_reg * dy1_reg;
        pxd_next = wx1_reg * dx1_reg;
        pyd_next = wy1_reg * dy1_reg;

        d2s_next  = {1'b0, sxx2_reg} + {1'b0, syy2_reg};
        d2e_next  = {1'b0, exx2_reg} + {1'b0, eyy2_reg};
        l_next    = {1'b0, dxx2_reg} + {1'b0, dyy2_reg};
        on_s_next = s_in2_reg && (d2s_next <= {2'b0, hh2_reg}) && (d2s_next >= {4'b0, ll2_reg});
        on_e_next = e_in2_reg && (d2e_next <= {2'b0, hh2_reg}) && (d2e_next >= {4'b0, ll2_reg});
        short_next = dx_in2_reg && dy_in2_reg && (l_next <= {18'b0, tt2_reg});
        dot_next  = {pxd2_reg[2*VEC_W], pxd2_reg} + {pyd2_reg[2*VEC_W], pyd2_reg};

        dm_next = dot3_reg[2*VEC_W+1] ? -dot3_reg : dot3_reg;

        r_next = 114'(p00_4_reg) + (114'(p01_4_reg) << 24)
               + (114'(p10_4_reg) << 33) + (114'(p11_4_reg) << 57);

        q_next = (116'(qa5_reg) << 58) + (116'(qb5_reg) << 30) + 116'(qc5_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[DEPTH-2:0], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vs_reg[0] <= '{x: vsx_next, y: vsy_next};
            ve_reg[0] <= '{x: vex_next, y: vey_next};
            for (int i = 1; i < DEPTH; i++)
            begin
                vs_reg[i] <= vs_reg[i-1];
                ve_reg[i] <= ve_reg[i-1];
            end
            dx1_reg <= dx_next;
            dy1_reg <= dy_next;
            wx1_reg <= wx_next;
            wy1_reg <= wy_next;
            hi1_reg <= hi_next;
            lo1_reg <= lo_next;

            sxx2_reg   <= sxx_next[2*COORD_W:0];
            syy2_reg   <= syy_next[2*COORD_W:0];
            exx2_reg   <= exx_next[2*COORD_W:0];
            eyy2_reg   <= eyy_next[2*COORD_W:0];
            dxx2_reg   <= dxx_next[2*COORD_W:0];
            dyy2_reg   <= dyy_next[2*COORD_W:0];
            pxd2_reg   <= pxd_next;
            pyd2_reg   <= pyd_next;
            hh2_reg    <= hi1_reg * hi1_reg;
            ll2_reg    <= lo1_reg * lo1_reg;
            tt2_reg    <= cfg.lin_tol * cfg.lin_tol;
            s_in2_reg  <= in_range(vs_reg[0].x, hi1_reg) && in_range(vs_reg[0].y, hi1_reg);
            e_in2_reg  <= in_range(ve_reg[0].x, hi1_reg) && in_range(ve_reg[0].y, hi1_reg);
            dx_in2_reg <= in_range(dx1_reg, tol32);
            dy_in2_reg <= in_range(dy1_reg, tol32);

            rad_ok3_reg <= on_s_next && on_e_next;
            short3_reg  <= short_next;
            l3_reg      <= l_next;
            tt3_reg     <= tt2_reg;
            dot3_reg    <= dot_next;

            rad_ok4_reg <= rad_ok3_reg;
            short4_reg  <= short3_reg;
            small4_reg  <= (dm_next[2*VEC_W+1:58] == '0);
            dm4_reg     <= dm_next[57:0];
            p00_4_reg   <= l3_reg[32:0] * tt3_reg[23:0];
            p01_4_reg   <= l3_reg[32:0] * tt3_reg[47:24];
            p10_4_reg   <= l3_reg[65:33] * tt3_reg[23:0];
            p11_4_reg   <= l3_reg[65:33] * tt3_reg[47:24];

            rad_ok5_reg <= rad_ok4_reg;
            short5_reg  <= short4_reg;
            small5_reg  <= small4_reg;
            qa5_reg     <= dm4_reg[57:29] * dm4_reg[57:29];
            qb5_reg     <= dm4_reg[57:29] * dm4_reg[28:0];
            qc5_reg     <= dm4_reg[28:0] * dm4_reg[28:0];
            r5_reg      <= r_next;

            rad_ok6_reg <= rad_ok5_reg;
            short6_reg  <= short5_reg;
            small6_reg  <= small5_reg;
            q6_reg      <= q_next;
            r6_reg      <= r5_reg;

            flags7_reg.is_short  <= short6_reg;
            flags7_reg.radius_ok <= rad_ok6_reg;
            flags7_reg.centre_ok <= small6_reg && (q6_reg <= {r6_reg, 2'b00});
        end
    end

    assign valid_out = v_reg[DEPTH-1];
    assign flags     = flags7_reg;
    assign start_vec = vs_reg[DEPTH-1];
    assign end_vec   = ve_reg[DEPTH-1];

endmodule

>>> hw/rtl/casc_cordic.sv
`timescale 1ns / 1ps
module casc_cordic #(
    parameter int STEPS = casc_pkg::DEF_CORDIC_STEPS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          valid_in,
    input  casc_pkg::front_t              flags_in,
    input  casc_pkg::vec_t                start_vec,
    input  casc_pkg::vec_t                end_vec,
    output logic                          valid_out,
    output casc_pkg::front_t              flags_out,
    output logic [casc_pkg::ANG_W-1:0]    from_angle,
    output logic [casc_pkg::ANG_W-1:0]    end_angle,
    output logic                          zero_vec
);
    import casc_pkg::*;

    localparam int NV  = 2;
    localparam int PAD = CW - VEC_W - ANG_W;

    logic [STEPS:0] v_reg;
    front_t tag_reg [STEPS+1];
    logic   zero_reg [STEPS+1];
    logic signed [CW-1:0] x_reg [STEPS+1][NV];
    logic signed [CW-1:0] y_reg [STEPS+1][NV];
    logic [ANG_W-1:0]     z_reg [STEPS+1][NV];

    logic signed [CW-1:0] x_next [STEPS+1][NV];
    logic signed [CW-1:0] y_next [STEPS+1][NV];
    logic [ANG_W-1:0]     z_next [STEPS+1][NV];

    always_comb
    begin
        vec_t vin [NV];
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        vin[0] = start_vec;
        vin[1] = end_vec;
        for (int k = 0; k < NV; k++)
        begin
            xs = {{PAD{vin[k].x[VEC_W-1]}}, vin[k].x, {ANG_W{1'b0}}};
            ys = {{PAD{vin[k].y[VEC_W-1]}}, vin[k].y, {ANG_W{1'b0}}};
            if (xs[CW-1])
            begin
                x_next[0][k] = -xs;
                y_next[0][k] = -ys;
                z_next[0][k] = HALF_TURN;
            end
            else
            begin
                x_next[0][k] = xs;
                y_next[0][k] = ys;
                z_next[0][k] = '0;
            end
        end
        for (int s = 0; s < STEPS; s++)
        begin
            for (int k = 0; k < NV; k++)
            begin
                if (!y_reg[s][k][CW-1])
                begin
                    x_next[s+1][k] = x_reg[s][k] + (y_reg[s][k] >>> s);
                    y_next[s+1][k] = y_reg[s][k] - (x_reg[s][k] >>> s);
                    z_next[s+1][k] = z_reg[s][k] + ATAN_TABLE[s];
                end
                else
                begin
                    x_next[s+1][k] = x_reg[s][k] - (y_reg[s][k] >>> s);
                    y_next[s+1][k] = y_reg[s][k] + (x_reg[s][k] >>> s);
                    z_next[s+1][k] = z_reg[s][k] - ATAN_TABLE[s];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[STEPS-1:0], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg       <= x_next;
            y_reg       <= y_next;
            z_reg       <= z_next;
            tag_reg[0]  <= flags_in;
            zero_reg[0] <= ((start_vec.x == '0) && (start_vec.y == '0))
                        || ((end_vec.x == '0) && (end_vec.y == '0));
            for (int s = 1; s <= STEPS; s++)
            begin
                tag_reg[s]  <= tag_reg[s-1];
                zero_reg[s] <= zero_reg[s-1];
            end
        end
    end

    assign valid_out  = v_reg[STEPS];
    assign flags_out  = tag_reg[STEPS];
    assign zero_vec   = zero_reg[STEPS];
    assign from_angle = z_reg[STEPS][0];
    assign end_angle  = z_reg[STEPS][1];

endmodule

>>> hw/rtl/casc_decide.sv
`timescale 1ns / 1ps
module casc_decide #(
    parameter int MAX_ARCS = casc_pkg::DEF_MAX_ARCS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic                       valid_in,
    input  casc_pkg::cfg_t             cfg,
    input  casc_pkg::front_t           flags,
    input  logic [casc_pkg::ANG_W-1:0] from_angle,
    input  logic [casc_pkg::ANG_W-1:0] end_angle,
    input  logic                       zero_vec,
    output logic                       out_valid,
    output logic                       is_arc
);
    import casc_pkg::*;

    localparam int NW = $clog2(MAX_ARCS + 1);
    localparam int PW = ANG_W + NW;
    localparam logic [NW-1:0] MAX_N     = NW'(MAX_ARCS);
    localparam logic [PW-1:0] FULL_TURN = PW'(1) << ANG_W;

    logic             v1_reg, v2_reg, out_valid_reg, is_arc_reg;
    front_t           flags1_reg, flags2_reg;
    logic             zero1_reg, zero2_reg, gt1_reg, gt2_reg;
    logic [ANG_W-1:0] diff1_reg;
    logic [PW-1:0]    prod2_reg;

    logic [ANG_W-1:0] sweep_next;
    logic [NW-1:0]    n_next;
    logic             bad_next, result_next;

    always_comb
    begin
        sweep_next = end_angle - from_angle;
        n_next     = (cfg.arcs > ARCS_W'(MAX_ARCS)) ? MAX_N : cfg.arcs[NW-1:0];
        bad_next   = (cfg.radius == '0) || (cfg.arcs == '0);
        if (flags2_reg.is_short)
        begin
            result_next = (cfg.arcs == ARCS_W'(1)) && flags2_reg.radius_ok;
        end
        else
        begin
            result_next = !zero2_reg && gt2_reg && (prod2_reg <= FULL_TURN)
                        && flags2_reg.centre_ok;
        end
        result_next = result_next && !bad_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= valid_in;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            flags1_reg <= flags;
            zero1_reg  <= zero_vec;
            gt1_reg    <= sweep_next > cfg.ang_tol;
            diff1_reg  <= sweep_next - cfg.ang_tol;
            flags2_reg <= flags1_reg;
            zero2_reg  <= zero1_reg;
            gt2_reg    <= gt1_reg;
            prod2_reg  <= PW'(diff1_reg) * PW'(n_next);
            is_arc_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign is_arc    = is_arc_reg;

endmodule

>>> hw/rtl/casc_checker.sv
`timescale 1ns / 1ps
module casc_checker (
    input logic clk,
    input logic rst_n,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic is_arc
);

    // A result held back by the receiver stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(is_arc))
    else $error("result changed while stalled");

    // The input side only waits while a finished result is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

    // A result disappears only through a transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(!out_stall))
    else $error("result dropped without a transfer");

    // While no result is offered at the output, the input side never waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
    else $error("input stalled with an empty output");

endmodule

bind cylindrical_arc_segment_check casc_checker u_checker (.*);
